// ===== hdl/lecr_pkg.sv =====
// ---------------------------------------------------------------------------
// LED effect color renderer package
// Shared types, constants and constant tables for the renderer pipeline.
// ---------------------------------------------------------------------------
package lecr_pkg;

  localparam int COS_TABLE_BITS = 8;
  localparam int COS_SIZE       = 1 << COS_TABLE_BITS;

  localparam int PH_STAGES = 10;
  localparam int SH_STAGES = 5;

  localparam logic [2:0] EFF_OFF      = 3'd0;
  localparam logic [2:0] EFF_SOLID    = 3'd1;
  localparam logic [2:0] EFF_SNAKE    = 3'd2;
  localparam logic [2:0] EFF_RAINBOW  = 3'd3;
  localparam logic [2:0] EFF_BREATH   = 3'd4;
  localparam logic [2:0] EFF_GRADIENT = 3'd5;
  localparam logic [2:0] EFF_SHALLOW  = 3'd6;

  localparam logic [19:0] MOD_C  = 20'd1020000;
  localparam logic [20:0] REC_C  = 21'((64'd1 << 40) / 64'd1020000);
  localparam logic [28:0] REC_P  = 29'((64'd1 << 48) / 64'd1020000);

  localparam logic [15:0] SNAKE_W     = 16'd19661;
  localparam logic [7:0]  SNAKE_FLOOR = 8'd10;

  localparam logic [1:0] DSEL_SNAKE   = 2'd0;
  localparam logic [1:0] DSEL_BREATH  = 2'd1;
  localparam logic [1:0] DSEL_SHALLOW = 2'd2;

  localparam logic [17:0] DIV_SNAKE   = 18'd19661;
  localparam logic [17:0] DIV_BREATH  = 18'd65534;
  localparam logic [17:0] DIV_SHALLOW = 18'd131068;
  localparam logic [25:0] REC_SNAKE   = 26'((64'd1 << 40) / 64'd19661);
  localparam logic [25:0] REC_BREATH  = 26'((64'd1 << 40) / 64'd65534);
  localparam logic [25:0] REC_SHALLOW = 26'((64'd1 << 40) / 64'd131068);

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  bright;
    logic [2:0]  effect;
    logic [7:0]  pos8;
  } item_t;

  typedef logic signed [15:0] cos_tab_t [COS_SIZE];
  typedef logic [15:0] grad_tab_t [256];

  function automatic logic [15:0] cos_quarter(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] prod;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 << 30)) begin
      sum = 64'sd1 << 30;
    end
    prod = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return prod[15:0];
  endfunction

  function automatic cos_tab_t make_cos_tab();
    cos_tab_t tab;
    int quarter;
    int q;
    int r;
    int j;
    logic [15:0] v;
    quarter = 1 << (COS_TABLE_BITS - 2);
    for (int k = 0; k < COS_SIZE; k++) begin
      q = (k >> (COS_TABLE_BITS - 2)) & 3;
      r = k & (quarter - 1);
      j = (q % 2 == 1) ? quarter - r : r;
      v = cos_quarter((64'(j) * 64'd6746518852) >> COS_TABLE_BITS);
      tab[k] = (q == 1 || q == 2) ? -$signed(v) : $signed(v);
    end
    return tab;
  endfunction

  function automatic grad_tab_t make_grad_tab();
    grad_tab_t tab;
    int t;
    for (int i = 0; i < 256; i++) begin
      t = (i * 29491) / 255;
      tab[i] = 16'(t);
    end
    return tab;
  endfunction

  localparam cos_tab_t  COS_TAB  = make_cos_tab();
  localparam grad_tab_t GRAD_TAB = make_grad_tab();

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'd1 + 17'(x[15:8]);
    return s[15:8];
  endfunction

endpackage

// ===== hdl/led_effect_color_renderer_unit.sv =====
// ---------------------------------------------------------------------------
// LED effect color renderer
// Renders one RGB888 pixel per item from color, brightness, effect and time.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  input   | in_valid, in_stall  | base_color, brightness, effect_code,
//          |                     | speed, position, time_ms
//  output  | out_valid, out_stall| out_color
//
// One item is accepted per cycle while the output is not stalled; each item
// passes through the phase reduction multipliers and then the shading stages.
// Reset clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline, so in_stall follows out_stall
// whenever a result is waiting.
module led_effect_color_renderer_unit import lecr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] base_color,
  input  logic [7:0]  brightness,
  input  logic [2:0]  effect_code,
  input  logic [7:0]  speed,
  input  logic [7:0]  position,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_color
);

  logic        adv;
  item_t       item_in;
  item_t       ph_item;
  logic        ph_valid;
  logic [15:0] ph_phase;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign item_in  = '{color: base_color, bright: brightness,
                      effect: effect_code, pos8: position};

  lecr_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .item_in   (item_in),
    .time_ms   (time_ms),
    .speed     (speed),
    .out_valid (ph_valid),
    .item_out  (ph_item),
    .phase     (ph_phase)
  );

  lecr_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ph_valid),
    .item_in   (ph_item),
    .phase     (ph_phase),
    .out_valid (out_valid),
    .out_color (out_color)
  );

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_no_idle_stall: assert property (@(posedge clk) !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (ph_valid == $past(ph_valid)))
    else $error("pipeline moved during an output stall");

endmodule

// ===== hdl/lecr_phase.sv =====
// ---------------------------------------------------------------------------
// LED effect phase pipeline
// Reduces time times rate modulo one period and scales it to a Q0.16 phase.
// ---------------------------------------------------------------------------
module lecr_phase import lecr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  item_t       item_in,
  input  logic [31:0] time_ms,
  input  logic [7:0]  speed,
  output logic        out_valid,
  output item_t       item_out,
  output logic [15:0] phase
);

  logic [PH_STAGES-1:0] v;
  item_t it [PH_STAGES];

  logic [31:0] t1, t2;
  logic [10:0] m1, m2, m3;
  logic [12:0] q1;
  logic [31:0] qc1;
  logic [19:0] r1;
  logic [30:0] p4, p5, p6;
  logic [11:0] q5;
  logic [30:0] qc6;
  logic [19:0] n7, n8, n9;
  logic [15:0] q8, q9;
  logic [35:0] qc9;
  logic [15:0] ph;

  logic [52:0] prod1;
  logic [32:0] prod2;
  logic [31:0] r3;
  logic [51:0] prod5;
  logic [31:0] prod6;
  logic [30:0] r7;
  logic [48:0] prod8;
  logic [35:0] rem10;

  always_comb begin
    prod1 = 53'(time_ms) * 53'(REC_C);
    prod2 = 33'(q1) * 33'(MOD_C);
    r3    = t2 - qc1;
    prod5 = 52'(p4) * 52'(REC_C);
    prod6 = 32'(q5) * 32'(MOD_C);
    r7    = p6 - qc6;
    prod8 = 49'(n7) * 49'(REC_P);
    rem10 = {n9, 16'd0} - qc9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[PH_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it[0] <= item_in;
      for (int i = 1; i < PH_STAGES; i++) begin
        it[i] <= it[i-1];
      end
      t1  <= time_ms;
      m1  <= 11'd255 + 11'(speed) * 11'd7;
      q1  <= prod1[52:40];
      t2  <= t1;
      m2  <= m1;
      qc1 <= prod2[31:0];
      m3  <= m2;
      r1  <= (r3[20:0] >= 21'(MOD_C)) ? 20'(r3[20:0] - 21'(MOD_C)) : r3[19:0];
      p4  <= 31'(r1) * 31'(m3);
      p5  <= p4;
      q5  <= prod5[51:40];
      p6  <= p5;
      qc6 <= prod6[30:0];
      n7  <= (r7[20:0] >= 21'(MOD_C)) ? 20'(r7[20:0] - 21'(MOD_C)) : r7[19:0];
      n8  <= n7;
      q8  <= prod8[47:32];
      n9  <= n8;
      q9  <= q8;
      qc9 <= 36'(q8) * 36'(MOD_C);
      ph  <= (rem10 >= 36'(MOD_C)) ? q9 + 16'd1 : q9;
    end
  end

  assign out_valid = v[PH_STAGES-1];
  assign item_out  = it[PH_STAGES-1];
  assign phase     = ph;

endmodule

// ===== hdl/lecr_shade.sv =====
// ---------------------------------------------------------------------------
// LED effect shading pipeline
// Forms the effect pulse or hue from the phase, or the gradient blend from the position, and scales the color.
// ---------------------------------------------------------------------------
module lecr_shade import lecr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  item_t       item_in,
  input  logic [15:0] phase,
  output logic        out_valid,
  output logic [23:0] out_color
);

  logic [SH_STAGES-1:0] v;
  item_t it [SH_STAGES];

  logic [24:0] num1, num2, num3;
  logic [1:0]  dsel1, dsel2, dsel3;
  logic        far1, far2, far3;
  logic [2:0]  sec1, sec2;
  logic [15:0] f1;
  logic [23:0] mx1, mx2, mx3;
  logic [7:0]  qe2, qe3;
  logic [7:0]  tt2, qq2;
  logic [24:0] qd3;
  logic [23:0] rb3, rb4;
  logic [23:0] col4;
  logic [7:0]  e4;
  logic        byp4, zero4;
  logic [23:0] res;

  logic [15:0] pos, d, dm, a;
  logic [16:0] dw, na;
  logic [17:0] x1;
  logic [1:0]  ds;
  logic signed [17:0] cext, bx, sx;
  logic [15:0] hue;
  logic [18:0] scaled;
  logic [25:0] rec;
  logic [50:0] prod2;
  logic [23:0] tp;
  logic [24:0] qp;
  logic [17:0] dv3, dv4;
  logic [24:0] rem4;
  logic [7:0]  pulse;
  logic [7:0]  ep;
  logic [24:0] mr, mg, mb;

  always_comb begin
    pos  = {item_in.pos8, item_in.pos8};
    d    = (pos >= phase) ? pos - phase : phase - pos;
    dw   = 17'h10000 - 17'(d);
    dm   = (dw < 17'(d)) ? dw[15:0] : d;
    cext = 18'(COS_TAB[phase[15 -: COS_TABLE_BITS]]);
    bx   = 18'sd32767 - cext;
    sx   = 18'sd98301 - cext;
    case (item_in.effect)
      EFF_SNAKE: begin
        x1 = (dm < SNAKE_W) ? 18'(SNAKE_W - dm) : 18'd0;
        ds = DSEL_SNAKE;
      end
      EFF_BREATH: begin
        x1 = $unsigned(bx);
        ds = DSEL_BREATH;
      end
      EFF_SHALLOW: begin
        x1 = $unsigned(sx);
        ds = DSEL_SHALLOW;
      end
      default: begin
        x1 = 18'd0;
        ds = DSEL_SNAKE;
      end
    endcase
    hue    = phase + pos;
    scaled = 19'(hue) * 19'd6;
    a      = GRAD_TAB[item_in.pos8];
    na     = 17'h10000 - 17'(a);
    mr     = 25'(item_in.color[23:16]) * 25'(na) + 25'(a) * 25'd255;
    mg     = 25'(item_in.color[15:8]) * 25'(na) + 25'(a) * 25'd255;
    mb     = 25'(item_in.color[7:0]) * 25'(na) + 25'(a) * 25'd255;
  end

  always_comb begin
    case (dsel1)
      DSEL_SNAKE:  rec = REC_SNAKE;
      DSEL_BREATH: rec = REC_BREATH;
      default:     rec = REC_SHALLOW;
    endcase
    prod2 = 51'(num1) * 51'(rec);
    tp    = 24'(it[0].bright) * 24'(f1);
    qp    = 25'(it[0].bright) * 25'(17'h10000 - 17'(f1));
    case (dsel2)
      DSEL_SNAKE:  dv3 = DIV_SNAKE;
      DSEL_BREATH: dv3 = DIV_BREATH;
      default:     dv3 = DIV_SHALLOW;
    endcase
    case (dsel3)
      DSEL_SNAKE:  dv4 = DIV_SNAKE;
      DSEL_BREATH: dv4 = DIV_BREATH;
      default:     dv4 = DIV_SHALLOW;
    endcase
    rem4 = num3 - qd3;
    if (far3) begin
      pulse = SNAKE_FLOOR;
    end else if (rem4 >= 25'(dv4)) begin
      pulse = qe3 + 8'd1;
    end else begin
      pulse = qe3;
    end
    ep = div255(16'(it[2].bright) * 16'(pulse));
    res = {div255(16'(col4[23:16]) * 16'(e4)),
           div255(16'(col4[15:8]) * 16'(e4)),
           div255(16'(col4[7:0]) * 16'(e4))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[SH_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it[0] <= item_in;
      for (int i = 1; i < SH_STAGES; i++) begin
        it[i] <= it[i-1];
      end
      num1  <= 25'(x1) * 25'd255;
      dsel1 <= ds;
      far1  <= (item_in.effect == EFF_SNAKE) && (dm >= SNAKE_W);
      sec1  <= scaled[18:16];
      f1    <= scaled[15:0];
      mx1   <= {mr[23:16], mg[23:16], mb[23:16]};

      qe2   <= prod2[47:40];
      num2  <= num1;
      dsel2 <= dsel1;
      far2  <= far1;
      sec2  <= sec1;
      tt2   <= tp[23:16];
      qq2   <= qp[23:16];
      mx2   <= mx1;

      qd3   <= 25'(qe2) * 25'(dv3);
      qe3   <= qe2;
      num3  <= num2;
      dsel3 <= dsel2;
      far3  <= far2;
      mx3   <= mx2;
      case (sec2)
        3'd0:    rb3 <= {it[1].bright, tt2, 8'd0};
        3'd1:    rb3 <= {qq2, it[1].bright, 8'd0};
        3'd2:    rb3 <= {8'd0, it[1].bright, tt2};
        3'd3:    rb3 <= {8'd0, qq2, it[1].bright};
        3'd4:    rb3 <= {tt2, 8'd0, it[1].bright};
        default: rb3 <= {it[1].bright, 8'd0, qq2};
      endcase

      rb4   <= rb3;
      zero4 <= (it[2].effect == EFF_OFF) || (it[2].bright == 8'd0);
      case (it[2].effect)
        EFF_SNAKE, EFF_BREATH, EFF_SHALLOW: begin
          col4 <= it[2].color;
          e4   <= ep;
          byp4 <= 1'b0;
        end
        EFF_RAINBOW: begin
          col4 <= it[2].color;
          e4   <= it[2].bright;
          byp4 <= 1'b1;
        end
        EFF_GRADIENT: begin
          col4 <= mx3;
          e4   <= it[2].bright;
          byp4 <= 1'b0;
        end
        default: begin
          col4 <= it[2].color;
          e4   <= it[2].bright;
          byp4 <= 1'b0;
        end
      endcase

      if (zero4) begin
        out_color <= 24'd0;
      end else if (byp4) begin
        out_color <= rb4;
      end else begin
        out_color <= res;
      end
    end
  end

  assign out_valid = v[SH_STAGES-1];

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// LED effect color renderer testbench
// Drives directed and random pixel items through the renderer with random
// gaps and stalls, predicts each rendered color and compares in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lecr_pkg::*;

  typedef struct {
    logic [23:0] color;
    logic [7:0]  bright;
    logic [2:0]  effect;
    logic [7:0]  speed;
    logic [7:0]  pos8;
    logic [31:0] tms;
    logic        has_color;
    logic [23:0] color_exp;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] base_color;
  logic [7:0]  brightness;
  logic [2:0]  effect_code;
  logic [7:0]  speed;
  logic [7:0]  position;
  logic [31:0] time_ms;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_color;

  logic [23:0] color_q[$];
  pixel_t      pixels[$];
  int          mismatches;
  int          cycles;
  bit          feed_done;
  logic signed [15:0] cos_rom [256];

  led_effect_color_renderer_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] quarter_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return 16'((longint'(acc) * 32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [23:0] dim(input logic [23:0] c, input int u);
    int r;
    int g;
    int b;
    r = c[23:16] * u / 255;
    g = c[15:8] * u / 255;
    b = c[7:0] * u / 255;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] render(input pixel_t p);
    longint unsigned n;
    int unsigned ph;
    int unsigned pos;
    int unsigned d;
    int unsigned pulse;
    int unsigned hue;
    int unsigned sect;
    int unsigned f;
    int unsigned v;
    int unsigned tt;
    int unsigned qq;
    int unsigned a;
    int          cv;
    logic [23:0] mix;
    int unsigned ch;
    n = (longint'(p.tms) * longint'(255 + 7 * p.speed)) % 1020000;
    ph = int'((n * 65536) / 1020000);
    pos = p.pos8 * 257;
    v = p.bright;
    if (p.effect == EFF_OFF || p.bright == 0) return 24'd0;
    case (p.effect)
      EFF_SNAKE: begin
        d = pos > ph ? pos - ph : ph - pos;
        if (65536 - d < d) d = 65536 - d;
        pulse = d < SNAKE_W ? 255 * (SNAKE_W - d) / SNAKE_W : SNAKE_FLOOR;
        return dim(p.color, v * pulse / 255);
      end
      EFF_RAINBOW: begin
        hue = (ph + pos) & 16'hFFFF;
        sect = (hue * 6) >> 16;
        f = (hue * 6) & 16'hFFFF;
        tt = (v * f) >> 16;
        qq = (v * (65536 - f)) >> 16;
        case (sect)
          0: return {v[7:0], tt[7:0], 8'd0};
          1: return {qq[7:0], v[7:0], 8'd0};
          2: return {8'd0, v[7:0], tt[7:0]};
          3: return {8'd0, qq[7:0], v[7:0]};
          4: return {tt[7:0], 8'd0, v[7:0]};
          default: return {v[7:0], 8'd0, qq[7:0]};
        endcase
      end
      EFF_BREATH, EFF_SHALLOW: begin
        cv = cos_rom[ph >> 8];
        if (p.effect == EFF_BREATH) pulse = 255 * (32767 - cv) / 65534;
        else pulse = 255 * (98301 - cv) / 131068;
        return dim(p.color, v * pulse / 255);
      end
      EFF_GRADIENT: begin
        a = p.pos8 * 29491 / 255;
        for (int sh = 0; sh < 24; sh += 8) begin
          ch = (((p.color >> sh) & 8'hFF) * (65536 - a) + 255 * a) >> 16;
          mix[sh +: 8] = ch[7:0];
        end
        return dim(mix, v);
      end
      default: return dim(p.color, v);
    endcase
  endfunction

  function automatic pixel_t mk(input logic [23:0] c, input logic [7:0] b,
                                input logic [2:0] e, input logic [7:0] s,
                                input logic [7:0] p, input logic [31:0] t,
                                input logic hc = 1'b0, input logic [23:0] ce = 24'd0);
    pixel_t x;
    x.color = c; x.bright = b; x.effect = e; x.speed = s; x.pos8 = p;
    x.tms = t; x.has_color = hc; x.color_exp = ce;
    return x;
  endfunction

  function automatic pixel_t rnd_pixel();
    pixel_t x;
    x = mk(24'($urandom), 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
           $urandom);
    if ($urandom_range(0, 9) == 0) x.bright = 8'd255;
    if ($urandom_range(0, 9) == 0) x.tms = $urandom_range(0, 5000);
    return x;
  endfunction

  task automatic send(input pixel_t x);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base_color <= x.color;
    brightness <= x.bright;
    effect_code <= x.effect;
    speed <= x.speed;
    position <= x.pos8;
    time_ms <= x.tms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    color_q.push_back(x.has_color ? x.color_exp : render(x));
  endtask

  initial begin
    int v;
    for (int k = 0; k < 256; k++) begin
      v = (k >> 6) & 3;
      cos_rom[k] = (v == 1 || v == 2)
        ? -$signed(quarter_cos((64'((v % 2) ? 64 - (k & 63) : (k & 63))
                                * 64'd6746518852) >> 8))
        : $signed(quarter_cos((64'((v % 2) ? 64 - (k & 63) : (k & 63))
                               * 64'd6746518852) >> 8));
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    base_color = '0; brightness = '0; effect_code = EFF_OFF;
    speed = '0; position = '0; time_ms = '0;
    feed_done = 1'b0;
    pixels.push_back(mk(24'hFFFFFF, 8'd255, EFF_OFF, 8'd255, 8'd255, 32'hFFFFFFFF,
                        1'b1, 24'd0));
    pixels.push_back(mk(24'hFFFFFF, 8'd0, EFF_RAINBOW, 8'd0, 8'd0, 32'd0, 1'b1, 24'd0));
    pixels.push_back(mk(24'hFFFFFF, 8'd255, EFF_SOLID, 8'd0, 8'd0, 32'd0,
                        1'b1, 24'hFFFFFF));
    pixels.push_back(mk(24'h123456, 8'd255, 3'd7, 8'd77, 8'd9, 32'd99,
                        1'b1, 24'h123456));
    pixels.push_back(mk(24'h000000, 8'd255, EFF_SOLID, 8'd255, 8'd255, 32'hFFFFFFFF,
                        1'b1, 24'd0));
    pixels.push_back(mk(24'hFFFFFF, 8'd255, EFF_RAINBOW, 8'd0, 8'd0, 32'd0,
                        1'b1, 24'hFF0000));
    for (int e = 0; e < 8; e++) begin
      pixels.push_back(mk(24'hA5C3F0, 8'd200, 3'(e), 8'd0, 8'd0, 32'd0));
      pixels.push_back(mk(24'h5A3C0F, 8'd255, 3'(e), 8'd255, 8'd255, 32'hFFFFFFFF));
    end
    pixels.push_back(mk(24'hFFFFFF, 8'd255, EFF_SNAKE, 8'd128, 8'd128, 32'd1234));
    pixels.push_back(mk(24'h808080, 8'd1, EFF_GRADIENT, 8'd1, 8'd255, 32'd500));
    pixels.push_back(mk(24'hFFFFFF, 8'd255, EFF_SHALLOW, 8'd10, 8'd3, 32'd2000));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (pixels[i]) send(pixels[i]);
    for (int i = 0; i < 500; i++) begin
      if (i == 250) begin
        in_valid <= 1'b0;
        while (color_q.size() != 0) @(posedge clk);
      end
      send(rnd_pixel());
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;
  end

  // The receiver holds off each item for a random number of cycles.
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      w = $urandom_range(0, 3);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (rst || out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: color %06h", out_color);
      end else begin
        want = color_q.pop_front();
        if (out_color !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("color mismatch: expected %06h got %06h", want, out_color);
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (feed_done && color_q.size() == 0) begin
        repeat (40) @(posedge clk);
        if (mismatches == 0 && color_q.size() == 0) begin
          $display("[led_effect_color_renderer_unit] OK");
        end else begin
          $display("[led_effect_color_renderer_unit] ERROR");
        end
        $finish;
      end else if (cycles > 40000) begin
        $display("[led_effect_color_renderer_unit] ERROR");
        $finish;
      end
    end
  end

endmodule
